>>> rtl/pidtc_pkg.sv
package pidtc_pkg;

    localparam int DATA_W        = 32;
    localparam int TICKS_W       = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int FRAC_W        = 16;
    localparam int PROD_W        = 2 * DATA_W;
    // product with the fraction bits dropped
    localparam int TERM_W        = PROD_W - FRAC_W;
    localparam int TICK_LOG2_DEF = 16;
    localparam int TICK_LOG2_MAX = 24;
    // dividend of the derivative division and width of the q * ticks product
    localparam int DIVD_W        = TERM_W + TICK_LOG2_MAX;
    // quotient bits kept; the derivative magnitude stops at 2^(QUO_W-1)
    localparam int QUO_W         = 49;
    localparam int SUM_W         = 52;
    localparam int S_DATA_W      = 64;
    localparam int M_DATA_W      = 64;
    localparam int M_USER_W      = 2;

    // bit places in the stream words
    localparam int S_TICKS_LO    = DATA_W;
    localparam int S_RESTART_BIT = DATA_W + TICKS_W;
    localparam int USER_SKIP     = 0;
    localparam int USER_ZERO     = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEGRAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_POSITION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ELAPSED_LIMIT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_PRESET = 3'd7;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [TICKS_W-1:0]       TICKS_ALL = {TICKS_W{1'b1}};

    typedef struct packed {
        logic signed [DATA_W-1:0]  gain_prop;
        logic signed [DATA_W-1:0]  gain_integral;
        logic signed [DATA_W-1:0]  gain_deriv;
        logic signed [DATA_W-1:0]  target_position;
        logic signed [DATA_W-1:0]  drive_min;
        logic signed [DATA_W-1:0]  drive_max;
        logic        [TICKS_W-1:0] elapsed_limit;
        logic signed [DATA_W-1:0]  integral_preset;
    } cfg_t;

    // saturate a wide signed value to the Q16.16 range
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [DIVD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (!v[DIVD_W-1] && (|v[DIVD_W-2:DATA_W-1])) begin
            r = DATA_MAX;
        end else if (v[DIVD_W-1] && !(&v[DIVD_W-2:DATA_W-1])) begin
            r = DATA_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/pid_trapezoid_clamped_core.sv
// PID controller with trapezoidal integral, signed Q16.16.
// Input stream (s_*): one sample per item, position, elapsed ticks and a
// restart flag. Result stream (m_*): one item per sample with the clamped
// drive and the integral after the step; tuser flags a skipped sample and
// a zero interval. Gains, setpoint, clamps, tick limit and integral preset
// are written through the cfg_* port; the user must write them only while
// the block is idle, the block does not enforce it. An item is worked by a
// sequencer around one registered 32x32 multiplier and a restoring divider
// that yields one quotient bit a cycle. A normal sample runs S_DIFF to S_M5,
// S_INT, S_PA, S_WAIT while the divider runs, and S_DONE; a zero interval
// skips the divider; a skipped sample goes from S_DIFF to S_DONE. s_tready
// is high only in the idle state, so no sample is taken before the last is
// through. The result register lets the next sample be accepted while a
// result waits; if the receiver still stalls when the following result is
// ready, the sequencer holds until the register frees. Reset clears integral
// and previous error, loads the register defaults and empties both streams.
module pid_trapezoid_clamped_core #(
    parameter int TICK_RATE_LOG2 = pidtc_pkg::TICK_LOG2_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // position [31:0], elapsed_ticks [55:32], restart [56], zero [63:57]
    input  logic [pidtc_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // drive [31:0], integral_now [63:32]
    output logic [pidtc_pkg::M_DATA_W-1:0]        m_tdata,
    // skipped [0], zero_interval [1]
    output logic [pidtc_pkg::M_USER_W-1:0]        m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pidtc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pidtc_pkg::DATA_W-1:0]          cfg_data
);

    localparam int DATA_W  = pidtc_pkg::DATA_W;
    localparam int TICKS_W = pidtc_pkg::TICKS_W;
    localparam int TERM_W  = pidtc_pkg::TERM_W;
    localparam int DIVD_W  = pidtc_pkg::DIVD_W;
    localparam int SUM_W   = pidtc_pkg::SUM_W;
    localparam int FRAC_W  = pidtc_pkg::FRAC_W;
    localparam int PROD_W  = pidtc_pkg::PROD_W;
    localparam int QUO_W   = pidtc_pkg::QUO_W;
    localparam int HALF_W  = TICKS_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIFF = 4'd1;
    localparam logic [3:0] S_M0   = 4'd2;
    localparam logic [3:0] S_M1   = 4'd3;
    localparam logic [3:0] S_M2   = 4'd4;
    localparam logic [3:0] S_M3   = 4'd5;
    localparam logic [3:0] S_M4   = 4'd6;
    localparam logic [3:0] S_M5   = 4'd7;
    localparam logic [3:0] S_INT  = 4'd8;
    localparam logic [3:0] S_PA   = 4'd9;
    localparam logic [3:0] S_WAIT = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    pidtc_pkg::cfg_t cfg;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic signed [DATA_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] last_err_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] prev_reg;
    logic signed [DATA_W-1:0] diff_reg;
    logic signed [DATA_W-1:0] avg_reg;
    logic        [TICKS_W-1:0] ticks_reg;
    logic                     skip_reg;
    logic                     zero_reg;
    logic signed [TERM_W-1:0] p_reg;
    logic signed [TERM_W-1:0] q_reg;
    logic signed [TERM_W-1:0] r_reg;
    logic signed [DIVD_W-1:0] qt_reg;
    logic signed [SUM_W-1:0]  pa_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] drive_out_reg;
    logic signed [DATA_W-1:0] integ_out_reg;
    logic                     skip_out_reg;
    logic                     zero_out_reg;

    logic                     in_accept;
    logic                     out_load;
    logic signed [DATA_W-1:0] in_pos;
    logic        [TICKS_W-1:0] in_ticks;
    logic                     in_restart;

    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;

    logic                     div_start;
    logic                     div_busy;
    logic [QUO_W-1:0]         div_mag;
    logic [TERM_W-1:0]        r_mag;
    logic [DIVD_W-1:0]        dividend;

    logic signed [DATA_W:0]   avg_sum;
    logic signed [DIVD_W-1:0] inc;
    logic signed [SUM_W-1:0]  d_term;
    logic signed [SUM_W-1:0]  lo_ext;
    logic signed [SUM_W-1:0]  hi_ext;
    logic signed [DATA_W-1:0] drive_val;

    pidtc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidtc_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    pidtc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (ticks_reg),
        .busy     (div_busy),
        .mag      (div_mag)
    );

    assign in_pos     = s_tdata[DATA_W-1:0];
    assign in_ticks   = s_tdata[pidtc_pkg::S_TICKS_LO +: TICKS_W];
    assign in_restart = s_tdata[pidtc_pkg::S_RESTART_BIT];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {integ_out_reg, drive_out_reg};
    assign m_tuser  = {zero_out_reg, skip_out_reg};

    // operand selection for the shared multiplier
    always_comb begin
        case (state_reg)
            S_M0: begin
                mul_a = cfg.gain_prop;
                mul_b = err_reg;
            end
            S_M1: begin
                mul_a = cfg.gain_integral;
                mul_b = avg_reg;
            end
            S_M2: begin
                mul_a = cfg.gain_deriv;
                mul_b = diff_reg;
            end
            S_M3: begin
                // upper half of q, signed
                mul_a = DATA_W'($signed(q_reg[TERM_W-1:HALF_W]));
                mul_b = DATA_W'(ticks_reg);
            end
            S_M4: begin
                mul_a = DATA_W'(q_reg[HALF_W-1:0]);
                mul_b = DATA_W'(ticks_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign r_mag     = r_reg[TERM_W-1] ? TERM_W'(-r_reg) : TERM_W'(r_reg);
    assign dividend  = DIVD_W'(r_mag) << TICK_RATE_LOG2;
    assign div_start = (state_reg == S_M5) && !zero_reg;

    assign avg_sum = (DATA_W+1)'(err_reg) + (DATA_W+1)'(prev_reg);
    assign inc     = qt_reg >>> TICK_RATE_LOG2;
    assign d_term  = zero_reg ? '0
                   : (r_reg[TERM_W-1] ? -SUM_W'(div_mag) : SUM_W'(div_mag));
    assign lo_ext  = SUM_W'(cfg.drive_min);
    assign hi_ext  = SUM_W'(cfg.drive_max);

    // lower clamp wins when the limits are inverted
    always_comb begin
        if (skip_reg) begin
            drive_val = '0;
        end else if (sum_reg < lo_ext) begin
            drive_val = cfg.drive_min;
        end else if (sum_reg >= hi_ext) begin
            drive_val = cfg.drive_max;
        end else begin
            drive_val = sum_reg[DATA_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_accept) state_next = S_DIFF;
            S_DIFF: begin
                state_next = (ticks_reg > cfg.elapsed_limit) ? S_DONE : S_M0;
            end
            S_M0:   state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_M4;
            S_M4:   state_next = S_M5;
            S_M5:   state_next = S_INT;
            S_INT:  state_next = S_PA;
            S_PA:   state_next = S_WAIT;
            S_WAIT: if (!div_busy) state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            acc_reg      <= '0;
            last_err_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (in_accept && in_restart) begin
                acc_reg <= cfg.integral_preset;
            end else if (state_reg == S_INT) begin
                acc_reg <= pidtc_pkg::sat_data(DIVD_W'(acc_reg) + inc);
            end
            if (state_reg == S_DIFF) begin
                last_err_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                err_reg   <= pidtc_pkg::sat_data(DIVD_W'(cfg.target_position) - DIVD_W'(in_pos));
                prev_reg  <= in_restart ? '0 : last_err_reg;
                ticks_reg <= in_ticks;
            end
            S_DIFF: begin
                diff_reg <= pidtc_pkg::sat_data(DIVD_W'(err_reg) - DIVD_W'(prev_reg));
                avg_reg  <= avg_sum[DATA_W:1];
                skip_reg <= ticks_reg > cfg.elapsed_limit;
                zero_reg <= (ticks_reg == '0);
            end
            S_M1: p_reg <= prod[PROD_W-1:FRAC_W];
            S_M2: q_reg <= prod[PROD_W-1:FRAC_W];
            S_M3: r_reg <= prod[PROD_W-1:FRAC_W];
            // upper partial product lands above the low half of q
            S_M4: qt_reg <= {prod[DIVD_W-HALF_W-1:0], {HALF_W{1'b0}}};
            S_M5: qt_reg <= qt_reg + DIVD_W'(prod[2*HALF_W-1:0]);
            S_PA: pa_reg <= SUM_W'(p_reg) + SUM_W'(acc_reg);
            S_WAIT: sum_reg <= pa_reg + d_term;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            drive_out_reg <= drive_val;
            integ_out_reg <= acc_reg;
            skip_out_reg  <= skip_reg;
            zero_out_reg  <= zero_reg && !skip_reg;
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again straight after an accepted item");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[pidtc_pkg::USER_SKIP] && m_tuser[pidtc_pkg::USER_ZERO]))
        else $error("skipped result also marked as zero interval");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_busy)
        else $error("divider still running with the sequencer idle");

    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

>>> rtl/pidtc_cfg.sv
module pidtc_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pidtc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pidtc_pkg::DATA_W-1:0]      cfg_data,
    output pidtc_pkg::cfg_t                   cfg
);

    pidtc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_prop       <= '0;
            cfg_reg.gain_integral   <= '0;
            cfg_reg.gain_deriv      <= '0;
            cfg_reg.target_position <= '0;
            cfg_reg.drive_min       <= pidtc_pkg::DATA_MIN;
            cfg_reg.drive_max       <= pidtc_pkg::DATA_MAX;
            cfg_reg.elapsed_limit   <= pidtc_pkg::TICKS_ALL;
            cfg_reg.integral_preset <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                pidtc_pkg::REG_GAIN_PROP:       cfg_reg.gain_prop       <= cfg_data;
                pidtc_pkg::REG_GAIN_INTEGRAL:   cfg_reg.gain_integral   <= cfg_data;
                pidtc_pkg::REG_GAIN_DERIV:      cfg_reg.gain_deriv      <= cfg_data;
                pidtc_pkg::REG_TARGET_POSITION: cfg_reg.target_position <= cfg_data;
                pidtc_pkg::REG_DRIVE_MIN:       cfg_reg.drive_min       <= cfg_data;
                pidtc_pkg::REG_DRIVE_MAX:       cfg_reg.drive_max       <= cfg_data;
                pidtc_pkg::REG_ELAPSED_LIMIT:
                    cfg_reg.elapsed_limit <= cfg_data[pidtc_pkg::TICKS_W-1:0];
                pidtc_pkg::REG_INTEGRAL_PRESET: cfg_reg.integral_preset <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/pidtc_mul.sv
module pidtc_mul (
    input  logic                                    aclk,
    input  logic signed [pidtc_pkg::DATA_W-1:0]     op_a,
    input  logic signed [pidtc_pkg::DATA_W-1:0]     op_b,
    output logic signed [pidtc_pkg::PROD_W-1:0]     prod
);

    logic signed [pidtc_pkg::PROD_W-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= pidtc_pkg::PROD_W'(op_a) * pidtc_pkg::PROD_W'(op_b);
    end

endmodule

>>> rtl/pidtc_div.sv
module pidtc_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [pidtc_pkg::DIVD_W-1:0]       dividend,
    input  logic [pidtc_pkg::TICKS_W-1:0]      divisor,
    output logic                               busy,
    output logic [pidtc_pkg::QUO_W-1:0]        mag
);

    localparam int DIVR_W = pidtc_pkg::TICKS_W;
    localparam int QUO_W  = pidtc_pkg::QUO_W;
    localparam int TOP_W  = pidtc_pkg::DIVD_W - QUO_W;
    localparam int CMP_W  = (TOP_W > DIVR_W) ? TOP_W : DIVR_W;
    localparam int CNT_W  = $clog2(QUO_W + 1);
    localparam logic [QUO_W-1:0] MAG_LIMIT = {1'b1, {(QUO_W-1){1'b0}}};

    logic [DIVR_W-1:0] rem_reg;
    logic [QUO_W-1:0]  work_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              ovf_reg;

    logic [TOP_W-1:0]  top;
    logic              top_ovf;
    logic [DIVR_W:0]   trial;
    logic              fits;
    logic [DIVR_W:0]   trial_sub;

    assign top       = dividend[pidtc_pkg::DIVD_W-1:QUO_W];
    assign top_ovf   = CMP_W'(top) >= CMP_W'(divisor);
    assign trial     = {rem_reg, work_reg[QUO_W-1]};
    assign fits      = trial >= {1'b0, divisor};
    assign trial_sub = trial - {1'b0, divisor};

    assign busy = busy_reg;
    // limit the magnitude on overflow or once the quotient reaches the top bit
    assign mag  = (ovf_reg || work_reg[QUO_W-1]) ? MAG_LIMIT : work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QUO_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            ovf_reg  <= top_ovf;
            rem_reg  <= top_ovf ? '0 : DIVR_W'(top);
            work_reg <= dividend[QUO_W-1:0];
        end else if (busy_reg) begin
            rem_reg  <= fits ? trial_sub[DIVR_W-1:0] : trial[DIVR_W-1:0];
            work_reg <= {work_reg[QUO_W-2:0], fits};
        end
    end

endmodule
